@@ hdl/sfr_pkg.sv @@
// Package: frame constants and result codes for the status frame receiver.
`timescale 1ns / 1ps

package sfr_pkg;

  localparam logic [7:0] HdrLow  = 8'hF0;
  localparam logic [7:0] HdrHigh = 8'hF1;

  // Payload bytes in one status frame.
  localparam int unsigned FrameLen = 6;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_NONE = 2'd0;
  localparam kind_t KIND_ACK  = 2'd1;
  localparam kind_t KIND_LOW  = 2'd2;
  localparam kind_t KIND_HIGH = 2'd3;

endpackage

@@ hdl/sfr_in_if.sv @@
// Interface: input byte channel, valid/ready with one received byte.
`timescale 1ns / 1ps

interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ hdl/sfr_out_if.sv @@
// Interface: result channel, valid/ready with frame flags and six frame bytes.
`timescale 1ns / 1ps

interface sfr_out_if;
  import sfr_pkg::*;

  logic       valid;
  logic       ready;
  logic       after_frame;
  kind_t      frame_kind;
  logic       check_ok;
  logic [7:0] byte_one;
  logic [7:0] byte_two;
  logic [7:0] byte_three;
  logic [7:0] byte_four;
  logic [7:0] byte_five;
  logic [7:0] byte_six;

  modport source (
    output valid, output after_frame, output frame_kind, output check_ok,
    output byte_one, output byte_two, output byte_three, output byte_four,
    output byte_five, output byte_six, input ready
  );
  modport sink (
    input valid, input after_frame, input frame_kind, input check_ok,
    input byte_one, input byte_two, input byte_three, input byte_four,
    input byte_five, input byte_six, output ready
  );
endinterface

@@ hdl/sfr_cell.sv @@
// Module: one byte cell of the collect chain, with a running XOR pass-through.
`timescale 1ns / 1ps

module sfr_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] data_in,
  input  logic [7:0] xor_in,
  output logic [7:0] data_out,
  output logic [7:0] xor_out
);

  logic [7:0] data;

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= data_in;
    end
  end

  assign data_out = data;
  assign xor_out  = xor_in ^ data;

endmodule

@@ hdl/status_frame_receiver.sv @@
// Module: top level of the status frame receiver, byte parser over a chain of cells.
`timescale 1ns / 1ps

// Channel  Dir  Payload                                          Transfer
// rx       in   rx_byte[7:0]                                     valid && ready
// res      out  after_frame, frame_kind[1:0], check_ok,          valid && ready
//               byte_one .. byte_six [7:0]
//
// One registered result per byte; a byte can be taken every cycle while no result stalls.
// The frame completes on its last byte: the first five payload bytes sit in a
// five-cell shift chain and the sixth is read straight from the input.
// Synchronous reset returns the parser to idle and empties the result register.
// A stalled result holds its register; rx.ready drops only while it is held or in reset.

module status_frame_receiver
  import sfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  sfr_in_if.sink    rx,
  sfr_out_if.source res
);

  localparam int unsigned NumCells = FrameLen - 1;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_AFTER,
    MODE_LOW,
    MODE_HIGH
  } mode_t;

  mode_t      mode;
  mode_t      mode_next;
  logic [2:0] held;
  logic [2:0] held_next;

  logic [7:0] b;
  logic       take;
  logic       collecting;
  logic       ack;
  logic       full;
  logic       shift_en;

  logic [7:0] cell_q [NumCells];
  logic [7:0] xor_c  [NumCells + 1];

  assign b        = rx.rx_byte;
  assign rx.ready = !rst && (!res.valid || res.ready);
  assign take     = rx.valid && rx.ready;

  assign collecting = (mode == MODE_LOW || mode == MODE_HIGH) &&
                      b != HdrLow && b != HdrHigh;
  assign ack  = collecting && mode == MODE_LOW && held == 3'd1 && b == ~cell_q[0];
  assign full = collecting && !ack && held == 3'(NumCells);
  assign shift_en = take && collecting;

  assign xor_c[0] = 8'h00;

  // cell 0 takes the newest byte; older bytes move toward the end of the chain
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    if (i == 0) begin : g_head
      sfr_cell u_cell (
        .clk     (clk),
        .shift   (shift_en),
        .data_in (b),
        .xor_in  (xor_c[i]),
        .data_out(cell_q[i]),
        .xor_out (xor_c[i+1])
      );
    end else begin : g_body
      sfr_cell u_cell (
        .clk     (clk),
        .shift   (shift_en),
        .data_in (cell_q[i-1]),
        .xor_in  (xor_c[i]),
        .data_out(cell_q[i]),
        .xor_out (xor_c[i+1])
      );
    end
  end

  always_comb begin
    mode_next = mode;
    held_next = held;
    if (b == HdrLow) begin
      mode_next = MODE_LOW;
      held_next = 3'd0;
    end else if (b == HdrHigh) begin
      mode_next = MODE_HIGH;
      held_next = 3'd0;
    end else if (collecting) begin
      if (ack || full) begin
        mode_next = MODE_AFTER;
        held_next = 3'd0;
      end else begin
        held_next = held + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      held      <= 3'd0;
      res.valid <= 1'b0;
    end else begin
      if (take) begin
        res.valid       <= 1'b1;
        mode            <= mode_next;
        held            <= held_next;
        res.after_frame <= (mode_next == MODE_AFTER);
        res.frame_kind  <= KIND_NONE;
        res.check_ok    <= 1'b0;
        res.byte_one    <= 8'h00;
        res.byte_two    <= 8'h00;
        res.byte_three  <= 8'h00;
        res.byte_four   <= 8'h00;
        res.byte_five   <= 8'h00;
        res.byte_six    <= 8'h00;
        if (ack) begin
          res.frame_kind <= KIND_ACK;
          res.byte_one   <= cell_q[0];
          res.byte_two   <= b;
        end else if (full) begin
          res.frame_kind <= (mode == MODE_LOW) ? KIND_LOW : KIND_HIGH;
          res.check_ok   <= (xor_c[NumCells] == b);
          res.byte_one   <= cell_q[4];
          res.byte_two   <= cell_q[3];
          res.byte_three <= cell_q[2];
          res.byte_four  <= cell_q[1];
          res.byte_five  <= cell_q[0];
          res.byte_six   <= b;
        end
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/sfr_checker.sv @@
// Module: port-level assertions for the status frame receiver, bound to the top level.
`timescale 1ns / 1ps

module sfr_checker
  import sfr_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       after_frame,
  input kind_t      frame_kind,
  input logic       check_ok,
  input logic [7:0] byte_one,
  input logic [7:0] byte_two,
  input logic [7:0] byte_three,
  input logic [7:0] byte_four,
  input logic [7:0] byte_five,
  input logic [7:0] byte_six
);

  // no frame: check flag and bytes all clear
  a_none_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_kind == KIND_NONE |->
      !check_ok && byte_one == 8'h00 && byte_two == 8'h00 && byte_three == 8'h00 &&
      byte_four == 8'h00 && byte_five == 8'h00 && byte_six == 8'h00)
    else $error("empty result carries data");

  a_ack_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_kind == KIND_ACK |->
      byte_two == ~byte_one && !check_ok && byte_three == 8'h00 &&
      byte_four == 8'h00 && byte_five == 8'h00 && byte_six == 8'h00)
    else $error("malformed command ack");

  a_check: assert property (@(posedge clk) disable iff (rst)
    out_valid && (frame_kind == KIND_LOW || frame_kind == KIND_HIGH) |->
      check_ok == ((byte_one ^ byte_two ^ byte_three ^ byte_four ^ byte_five) == byte_six))
    else $error("check flag disagrees with frame bytes");

  a_frame_after: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_kind != KIND_NONE |-> after_frame)
    else $error("completed frame without after-frame flag");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_kind) && $stable(byte_one))
    else $error("stalled result changed");

endmodule

bind status_frame_receiver sfr_checker u_sfr_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (res.valid),
  .out_ready  (res.ready),
  .after_frame(res.after_frame),
  .frame_kind (res.frame_kind),
  .check_ok   (res.check_ok),
  .byte_one   (res.byte_one),
  .byte_two   (res.byte_two),
  .byte_three (res.byte_three),
  .byte_four  (res.byte_four),
  .byte_five  (res.byte_five),
  .byte_six   (res.byte_six)
);
